/* rtl/fcp_pkg.sv */
// Framed command parser package: sizes, character codes, keyword table and result type.
// Self-contained; imported by framed_command_parser_unit.
package fcp_pkg;

   localparam int MAX_BODY_LEN = 32;
   localparam int PARAM_COUNT  = 3;
   localparam int OUT_PARAMS   = 3;
   localparam int KW_COUNT     = 7;
   localparam int KW_MAX_LEN   = 11;

   localparam int BODY_W  = $clog2(MAX_BODY_LEN + 1);
   localparam int FIDX_W  = $clog2(PARAM_COUNT + 2);
   localparam int KPOS_W  = 4;
   localparam int ACC_W   = 17;
   localparam int PROD_W  = ACC_W + 4;

   localparam logic [ACC_W-1:0]  ACC_CAP = ACC_W'(32768);
   localparam logic [15:0]       POS_MAX = 16'h7FFF;

   localparam logic [7:0] CH_OPEN  = 8'h3C;
   localparam logic [7:0] CH_CLOSE = 8'h3E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [1:0] NUM_SKIP   = 2'd0;
   localparam logic [1:0] NUM_DIGITS = 2'd1;
   localparam logic [1:0] NUM_DONE   = 2'd2;

   localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
      (KW_MAX_LEN*8)'("scan"),
      (KW_MAX_LEN*8)'("calibration"),
      (KW_MAX_LEN*8)'("stop"),
      (KW_MAX_LEN*8)'("resume"),
      (KW_MAX_LEN*8)'("pause"),
      (KW_MAX_LEN*8)'("monitor"),
      (KW_MAX_LEN*8)'("cancel")
   };
   localparam logic [KPOS_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd4, 4'd11, 4'd4, 4'd6, 4'd5, 4'd7, 4'd6
   };

   // character of keyword k at position pos; zero past the end
   function automatic logic [7:0] kw_char(input int k, input logic [KPOS_W-1:0] pos);
      logic [7:0] ch;
      ch = CH_NUL;
      if (pos < KW_LEN[k]) begin
         ch = KW_TEXT[k][(int'(KW_LEN[k]) - 1 - int'(pos))*8 +: 8];
      end
      return ch;
   endfunction

   typedef struct packed {
      logic [2:0]  code;
      logic [15:0] param1;
      logic [15:0] param2;
      logic [15:0] param3;
      logic [2:0]  updated;
   } rsp_type;

endpackage

/* rtl/framed_command_parser_unit.sv */
// Framed command parser top level: per-byte frame, keyword and number parsing.
// Depends on fcp_pkg.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_command_code, rsp_*_param, rsp_params_updated
//
// One byte per cycle while req_stall is low; all parsing state updates in the cycle the byte is accepted.
// A closing byte puts its result in the output register, or in the skid entry when the output register is held.
// Output register plus one skid entry: req_stall rises only when both hold results.
// Synchronous active-high reset clears frame state and the stored parameters.
module framed_command_parser_unit
   import fcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_command_code,
   output logic signed [15:0] rsp_first_param,
   output logic signed [15:0] rsp_second_param,
   output logic signed [15:0] rsp_third_param,
   output logic [2:0]         rsp_params_updated
);

   logic                    receiving_ff, receiving_in;
   logic [BODY_W-1:0]       body_count_ff, body_count_in;
   logic [FIDX_W-1:0]       field_index_ff, field_index_in;
   logic                    field_started_ff, field_started_in;
   logic                    body_ended_ff, body_ended_in;
   logic [KW_COUNT-1:0]     kw_cand_ff, kw_cand_in;
   logic [KPOS_W-1:0]       kw_pos_ff, kw_pos_in;
   logic [1:0]              num_phase_ff, num_phase_in;
   logic                    num_neg_ff, num_neg_in;
   logic [ACC_W-1:0]        num_acc_ff, num_acc_in;
   logic [15:0]             pend_ff [PARAM_COUNT];
   logic [15:0]             pend_in [PARAM_COUNT];
   logic [PARAM_COUNT-1:0]  pend_mask_ff, pend_mask_in;
   logic [15:0]             com_ff [PARAM_COUNT];
   logic [15:0]             com_in [PARAM_COUNT];

   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_ff, out_in;
   logic                    skid_valid_ff, skid_valid_in;
   rsp_type                 skid_ff, skid_in;

   logic                    accept, pop, push;
   rsp_type                 res;

   // end-of-field view of the state
   logic [15:0]             ef_pend [PARAM_COUNT];
   logic [PARAM_COUNT-1:0]  ef_mask;
   logic [FIDX_W-1:0]       ef_index;
   logic [15:0]             field_val;

   logic [2:0]              match;
   logic                    is_digit, is_space;
   logic [PROD_W-1:0]       acc_sum;
   logic [15:0]             res_par [OUT_PARAMS];
   logic [2:0]              res_mask;

   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign is_digit = (req_rx_byte >= CH_ZERO) && (req_rx_byte <= CH_NINE);
   assign is_space = (req_rx_byte == CH_SPACE) ||
                     ((req_rx_byte >= CH_TAB) && (req_rx_byte <= CH_CR));
   assign acc_sum  = PROD_W'(num_acc_ff) * PROD_W'(10) + PROD_W'(req_rx_byte - CH_ZERO);

   always_comb begin
      field_val = (num_acc_ff > ACC_W'(POS_MAX)) ? POS_MAX : num_acc_ff[15:0];
      if (num_neg_ff) begin
         field_val = 16'(ACC_W'(0) - num_acc_ff);
      end
      ef_mask  = pend_mask_ff;
      ef_index = field_index_ff;
      for (int i = 0; i < PARAM_COUNT; i++) begin
         ef_pend[i] = pend_ff[i];
         if (field_started_ff && (field_index_ff == FIDX_W'(i + 1))) begin
            ef_pend[i] = field_val;
            ef_mask[i] = 1'b1;
         end
      end
      if (field_started_ff && (field_index_ff <= FIDX_W'(PARAM_COUNT))) begin
         ef_index = field_index_ff + FIDX_W'(1);
      end
   end

   always_comb begin
      match = 3'd0;
      if ((field_index_ff != '0) || field_started_ff) begin
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_cand_ff[k] && (kw_pos_ff == KW_LEN[k])) begin
               match = 3'(k + 1);
            end
         end
      end
   end

   always_comb begin
      receiving_in     = receiving_ff;
      body_count_in    = body_count_ff;
      field_index_in   = field_index_ff;
      field_started_in = field_started_ff;
      body_ended_in    = body_ended_ff;
      kw_cand_in       = kw_cand_ff;
      kw_pos_in        = kw_pos_ff;
      num_phase_in     = num_phase_ff;
      num_neg_in       = num_neg_ff;
      num_acc_in       = num_acc_ff;
      pend_mask_in     = pend_mask_ff;
      pend_in          = pend_ff;
      com_in           = com_ff;
      push             = 1'b0;
      for (int i = 0; i < PARAM_COUNT; i++) begin
         if (ef_mask[i]) begin
            com_in[i] = ef_pend[i];
         end
      end
      for (int i = 0; i < OUT_PARAMS; i++) begin
         res_par[i]  = (i < PARAM_COUNT) ? com_in[i % PARAM_COUNT] : 16'd0;
         res_mask[i] = (i < PARAM_COUNT) ? ef_mask[i % PARAM_COUNT] : 1'b0;
      end
      res = '{code: match, param1: res_par[0], param2: res_par[1], param3: res_par[2],
              updated: res_mask};

      if (accept) begin
         priority if (!receiving_ff || (req_rx_byte == CH_OPEN) || (req_rx_byte == CH_CLOSE)
                      || (body_count_ff >= BODY_W'(MAX_BODY_LEN))) begin
            receiving_in     = !receiving_ff && (req_rx_byte == CH_OPEN);
            body_count_in    = '0;
            field_index_in   = '0;
            body_ended_in    = 1'b0;
            kw_cand_in       = '1;
            kw_pos_in        = '0;
            pend_mask_in     = '0;
            field_started_in = 1'b0;
            num_phase_in     = NUM_SKIP;
            num_neg_in       = 1'b0;
            num_acc_in       = '0;
            if (!receiving_ff) begin
               com_in = com_ff;
               if (req_rx_byte != CH_OPEN) begin
                  receiving_in   = 1'b0;
                  body_count_in  = body_count_ff;
                  field_index_in = field_index_ff;
                  body_ended_in  = body_ended_ff;
                  kw_cand_in     = kw_cand_ff;
                  kw_pos_in      = kw_pos_ff;
                  pend_mask_in   = pend_mask_ff;
                  field_started_in = field_started_ff;
                  num_phase_in   = num_phase_ff;
                  num_neg_in     = num_neg_ff;
                  num_acc_in     = num_acc_ff;
               end
            end else if (req_rx_byte == CH_CLOSE) begin
               push    = 1'b1;
               pend_in = ef_pend;
            end else begin
               com_in = com_ff;
            end
         end else begin
            com_in        = com_ff;
            body_count_in = body_count_ff + BODY_W'(1);
            if (!body_ended_ff) begin
               priority if (req_rx_byte == CH_NUL) begin
                  body_ended_in = 1'b1;
               end else if (req_rx_byte == CH_COMMA) begin
                  pend_in          = ef_pend;
                  pend_mask_in     = ef_mask;
                  field_index_in   = ef_index;
                  if (field_started_ff) begin
                     field_started_in = 1'b0;
                     num_phase_in     = NUM_SKIP;
                     num_neg_in       = 1'b0;
                     num_acc_in       = '0;
                  end
               end else begin
                  field_started_in = 1'b1;
                  if (field_index_ff == '0) begin
                     for (int k = 0; k < KW_COUNT; k++) begin
                        if ((kw_pos_ff >= KW_LEN[k]) || (kw_char(k, kw_pos_ff) != req_rx_byte)) begin
                           kw_cand_in[k] = 1'b0;
                        end
                     end
                     if (kw_pos_ff != '1) begin
                        kw_pos_in = kw_pos_ff + KPOS_W'(1);
                     end
                  end else if ((field_index_ff <= FIDX_W'(PARAM_COUNT)) &&
                               (num_phase_ff != NUM_DONE)) begin
                     priority if (is_digit) begin
                        num_acc_in   = (acc_sum > PROD_W'(ACC_CAP)) ? ACC_CAP : acc_sum[ACC_W-1:0];
                        num_phase_in = NUM_DIGITS;
                     end else if ((num_phase_ff == NUM_SKIP) && is_space) begin
                        num_phase_in = NUM_SKIP;
                     end else if ((num_phase_ff == NUM_SKIP) &&
                                  ((req_rx_byte == CH_PLUS) || (req_rx_byte == CH_MINUS))) begin
                        num_neg_in   = (req_rx_byte == CH_MINUS);
                        num_phase_in = NUM_DIGITS;
                     end else begin
                        num_phase_in = NUM_DONE;
                     end
                  end
               end
            end
         end
      end else begin
         com_in = com_ff;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = push;
            skid_in       = res;
         end else begin
            out_valid_in = push;
            out_in       = res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff     <= 1'b0;
         body_count_ff    <= '0;
         field_index_ff   <= '0;
         field_started_ff <= 1'b0;
         body_ended_ff    <= 1'b0;
         kw_cand_ff       <= '1;
         kw_pos_ff        <= '0;
         num_phase_ff     <= NUM_SKIP;
         num_neg_ff       <= 1'b0;
         num_acc_ff       <= '0;
         pend_mask_ff     <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
         for (int i = 0; i < PARAM_COUNT; i++) begin
            com_ff[i] <= '0;
         end
      end else begin
         receiving_ff     <= receiving_in;
         body_count_ff    <= body_count_in;
         field_index_ff   <= field_index_in;
         field_started_ff <= field_started_in;
         body_ended_ff    <= body_ended_in;
         kw_cand_ff       <= kw_cand_in;
         kw_pos_ff        <= kw_pos_in;
         num_phase_ff     <= num_phase_in;
         num_neg_ff       <= num_neg_in;
         num_acc_ff       <= num_acc_in;
         pend_mask_ff     <= pend_mask_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
         com_ff           <= com_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_command_code   = out_ff.code;
   assign rsp_first_param    = out_ff.param1;
   assign rsp_second_param   = out_ff.param2;
   assign rsp_third_param    = out_ff.param3;
   assign rsp_params_updated = out_ff.updated;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> (body_count_ff == '0))
      else $error("body count not cleared outside a frame");

   a_body_bound: assert property (@(posedge clock) disable iff (reset)
      body_count_ff <= BODY_W'(MAX_BODY_LEN))
      else $error("body count past limit");

   a_field_bound: assert property (@(posedge clock) disable iff (reset)
      field_index_ff <= FIDX_W'(PARAM_COUNT + 1))
      else $error("field index past last parameter");

   a_close_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && receiving_ff && (req_rx_byte == CH_CLOSE)) |=> out_valid_ff)
      else $error("closed frame produced no result");
`endif

endmodule
